>>> rtl/hbpq_pkg.sv
// Shared constants, types and helpers for the binary heap priority queue.
// Used by the channel interfaces, the level RAM, the level cell and the top level.
package hbpq_pkg;

    localparam int DEPTH  = 256;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 9;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int LVLS   = $clog2(DEPTH + 1);
    localparam int LVL_W  = $clog2(LVLS);
    localparam int OFF_W  = LVLS - 1;
    localparam int ADDR_W = 3;

    localparam logic [VAL_W-1:0] MOST_NEG  = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_REMOVED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_CAP  = 1'b1;

    // packet carrying the hole of a sift from one level cell to the next
    typedef struct packed {
        logic             vld;
        logic             up;
        logic [VAL_W-1:0] val;
        logic [IDX_W-1:0] idx;
        logic [OFF_W-1:0] off;
    } hbpq_pkt_t;

    typedef struct packed {
        logic             vld;
        logic             up;
        logic [OFF_W-1:0] row;
    } hbpq_rdreq_t;

    typedef struct packed {
        logic             vld;
        logic             side;
        logic [OFF_W-1:0] row;
        logic [VAL_W-1:0] data;
    } hbpq_wr_t;

    typedef struct packed {
        logic             min_mode;
        logic [CNT_W-1:0] n;
    } hbpq_ctl_t;

    typedef logic [1:0][VAL_W-1:0] hbpq_pair_t;

    function automatic logic ranks_above(input logic [VAL_W-1:0] a,
                                         input logic [VAL_W-1:0] b,
                                         input logic min_mode);
        logic signed [VAL_W-1:0] sa;
        logic signed [VAL_W-1:0] sb;
        sa = a;
        sb = b;
        return min_mode ? (sa < sb) : (sa > sb);
    endfunction

    // sibling-pair rows needed at one heap level
    function automatic int ram_rows(input int lvl);
        int first;
        int nodes;
        first = (1 << lvl) - 1;
        nodes = 1 << lvl;
        if (DEPTH - first < nodes)
        begin
            nodes = DEPTH - first;
        end
        return (nodes + 1) >> 1;
    endfunction

endpackage

>>> rtl/hbpq_ifs.sv
// Request and response channel interfaces of the heap queue.
// Depends on hbpq_pkg for field widths.
interface hbpq_req_if import hbpq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic signed [VAL_W-1:0] value_in;

    modport source (output valid, output cmd, output value_in, input ready);
    modport sink (input valid, input cmd, input value_in, output ready);
endinterface

interface hbpq_rsp_if import hbpq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value_out;
    logic [1:0]              status;
    logic [CNT_W-1:0]        entry_count;

    modport source (output valid, output value_out, output status, output entry_count,
                    input ready);
    modport sink (input valid, input value_out, input status, input entry_count,
                  output ready);
endinterface

>>> rtl/hbpq_ram.sv
// Generic sibling-pair RAM: one row holds two heap entries, per-lane write.
// Registered read every cycle. Depends on hbpq_pkg.
module hbpq_ram import hbpq_pkg::*; #(
    parameter int ROWS = 2,
    parameter int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic             clk,
    input  logic [1:0]       we,
    input  logic [AW-1:0]    wr_row,
    input  logic [VAL_W-1:0] wr_data,
    input  logic [AW-1:0]    rd_row,
    output hbpq_pair_t       rd_data
);

    hbpq_pair_t mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (we[0])
        begin
            mem[wr_row][0] <= wr_data;
        end
        if (we[1])
        begin
            mem[wr_row][1] <= wr_data;
        end
        rd_data <= mem[rd_row];
    end

endmodule

>>> rtl/hbpq_cell.sv
// One heap level cell: owns the writes of its level, reads a neighbour level,
// compares and hands the sift packet on. Depends on hbpq_pkg.
module hbpq_cell import hbpq_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  hbpq_ctl_t   ctl,
    input  hbpq_pkt_t   pkt_in,
    output hbpq_pkt_t   pkt_out,
    input  hbpq_pair_t  rd_up,
    input  hbpq_pair_t  rd_dn,
    output hbpq_rdreq_t rq,
    output hbpq_wr_t    wr,
    output logic        done
);

    logic       busy_reg;
    logic       busy_next;
    hbpq_pkt_t  hold_reg;
    hbpq_pkt_t  hold_next;
    hbpq_pkt_t  pkt_out_reg;
    hbpq_pkt_t  pkt_out_next;

    logic [IDX_W+1:0] n_ext;
    logic [IDX_W+1:0] lft_in;
    logic [IDX_W+1:0] lft_hold;
    logic [IDX_W+1:0] rgt_hold;
    logic [VAL_W-1:0] par_val;
    logic [VAL_W-1:0] pick_val;
    logic             pick_rgt;
    logic [IDX_W-1:0] par_idx;
    logic [IDX_W-1:0] kid_idx;
    logic [OFF_W-1:0] kid_off;

    assign n_ext    = (IDX_W+2)'(ctl.n);
    assign lft_in   = {1'b0, pkt_in.idx, 1'b1};
    assign lft_hold = {1'b0, hold_reg.idx, 1'b1};
    assign rgt_hold = lft_hold + (IDX_W+2)'(1);
    assign par_val  = rd_up[hold_reg.off[1]];
    assign pick_rgt = (rgt_hold < n_ext) && !ranks_above(rd_dn[0], rd_dn[1], ctl.min_mode);
    assign pick_val = pick_rgt ? rd_dn[1] : rd_dn[0];
    assign par_idx  = (hold_reg.idx - IDX_W'(1)) >> 1;
    assign kid_idx  = pick_rgt ? IDX_W'(rgt_hold) : IDX_W'(lft_hold);
    assign kid_off  = {hold_reg.off[OFF_W-2:0], pick_rgt};

    always_comb
    begin
        wr           = '0;
        rq           = '0;
        done         = 1'b0;
        pkt_out_next = '0;
        busy_next    = 1'b0;
        hold_next    = hold_reg;
        if (pkt_in.vld)
        begin
            hold_next = pkt_in;
            wr.side   = pkt_in.off[0];
            wr.row    = pkt_in.off >> 1;
            wr.data   = pkt_in.val;
            if (pkt_in.up)
            begin
                if (pkt_in.idx == '0)
                begin
                    wr.vld = 1'b1;
                    done   = 1'b1;
                end
                else
                begin
                    rq.vld    = 1'b1;
                    rq.up     = 1'b1;
                    rq.row    = pkt_in.off >> 2;
                    busy_next = 1'b1;
                end
            end
            else
            begin
                if (lft_in >= n_ext)
                begin
                    wr.vld = 1'b1;
                    done   = 1'b1;
                end
                else
                begin
                    rq.vld    = 1'b1;
                    rq.up     = 1'b0;
                    rq.row    = pkt_in.off;
                    busy_next = 1'b1;
                end
            end
        end
        else if (busy_reg)
        begin
            wr.vld  = 1'b1;
            wr.side = hold_reg.off[0];
            wr.row  = hold_reg.off >> 1;
            wr.data = hold_reg.val;
            if (hold_reg.up)
            begin
                if (ranks_above(hold_reg.val, par_val, ctl.min_mode))
                begin
                    wr.data          = par_val;
                    pkt_out_next.vld = 1'b1;
                    pkt_out_next.up  = 1'b1;
                    pkt_out_next.val = hold_reg.val;
                    pkt_out_next.idx = par_idx;
                    pkt_out_next.off = hold_reg.off >> 1;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            else
            begin
                if (ranks_above(pick_val, hold_reg.val, ctl.min_mode))
                begin
                    wr.data          = pick_val;
                    pkt_out_next.vld = 1'b1;
                    pkt_out_next.up  = 1'b0;
                    pkt_out_next.val = hold_reg.val;
                    pkt_out_next.idx = kid_idx;
                    pkt_out_next.off = kid_off;
                end
                else
                begin
                    done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            pkt_out_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            pkt_out_reg <= pkt_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign pkt_out = pkt_out_reg;

endmodule

>>> rtl/binary_heap_priority_queue_unit.sv
// Binary heap priority queue: one level cell and one pair RAM per heap level.
// A sift packet walks the level cells one level at a time; at each level the cell
// reads the neighbour level, then compares and writes; a remove first fetches the last entry.
// The next request is taken once the result sits in the output register.
// Reset empties the queue, min order, capacity 256.
// Depends on hbpq_pkg, hbpq_ifs, hbpq_ram and hbpq_cell.
module binary_heap_priority_queue_unit import hbpq_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    hbpq_req_if.sink          req,
    hbpq_rsp_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             mode_reg;
    logic [CNT_W-1:0] cap_reg;
    hbpq_pkt_t        inj_reg;
    hbpq_pkt_t        inj_next;
    logic [LVL_W-1:0] inj_lvl_reg;
    logic [LVL_W-1:0] inj_lvl_next;
    logic [LVL_W-1:0] last_lvl_reg;
    logic [LVL_W-1:0] last_lvl_next;
    logic [OFF_W-1:0] last_off_reg;
    logic [OFF_W-1:0] last_off_next;
    logic [VAL_W-1:0] res_val_reg;
    logic [VAL_W-1:0] res_val_next;
    logic [1:0]       res_st_reg;
    logic [1:0]       res_st_next;
    logic             out_vld_reg;
    logic             out_vld_next;
    logic [VAL_W-1:0] out_val_reg;
    logic [VAL_W-1:0] out_val_next;
    logic [1:0]       out_st_reg;
    logic [1:0]       out_st_next;
    logic [CNT_W-1:0] out_cnt_reg;
    logic [CNT_W-1:0] out_cnt_next;

    logic             req_fire;
    logic             cfg_wr;
    logic [CNT_W-1:0] cap_eff;
    logic [IDX_W-1:0] ins_pos;
    logic [IDX_W-1:0] last_pos;
    hbpq_ctl_t        ctl;

    hbpq_pkt_t   cell_in  [LVLS];
    hbpq_pkt_t   cell_out [LVLS];
    hbpq_rdreq_t cell_rq  [LVLS];
    hbpq_wr_t    cell_wr  [LVLS];
    hbpq_pair_t  ram_rd   [LVLS];
    hbpq_pair_t  nb_up    [LVLS];
    hbpq_pair_t  nb_dn    [LVLS];
    hbpq_pkt_t   pk_above [LVLS];
    hbpq_pkt_t   pk_below [LVLS];
    logic [OFF_W-1:0] rq_above [LVLS];
    logic [OFF_W-1:0] rq_below [LVLS];
    logic [LVLS-1:0]  cell_done;

    function automatic logic [LVL_W-1:0] idx_lvl(input logic [IDX_W-1:0] p);
        logic [IDX_W:0]   q;
        logic [LVL_W-1:0] lv;
        q  = {1'b0, p} + (IDX_W+1)'(1);
        lv = '0;
        for (int b = 0; b <= IDX_W; b++)
        begin
            if (q[b])
            begin
                lv = LVL_W'(b);
            end
        end
        return lv;
    endfunction

    function automatic logic [OFF_W-1:0] idx_off(input logic [IDX_W-1:0] p);
        logic [IDX_W:0] q;
        q = {1'b0, p} + (IDX_W+1)'(1);
        q = q & ~((IDX_W+1)'(1) << idx_lvl(p));
        return OFF_W'(q);
    endfunction

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[ADDR_W-1:2] == REG_CAP) ? 32'(cap_reg) : 32'(mode_reg);
    assign cap_eff = (cap_reg > DEPTH_CNT) ? DEPTH_CNT : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
            cap_reg  <= DEPTH_CNT;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[ADDR_W-1:2])
                REG_MODE: mode_reg <= pwdata[0];
                REG_CAP:  cap_reg  <= pwdata[CNT_W-1:0];
                default:  ;
            endcase
        end
    end

    // level cells and their RAMs
    assign ctl.min_mode = mode_reg;
    assign ctl.n        = count_reg;

    genvar lv;
    generate
        for (lv = 0; lv < LVLS; lv++)
        begin : g_lvl
            localparam int ROWS = ram_rows(lv);
            localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

            logic [OFF_W-1:0] row_full;
            logic [OFF_W-1:0] fetch_row;
            logic [1:0]       we;
            hbpq_pkt_t        inj_here;

            if (lv > 0)
            begin : g_above
                assign rq_above[lv] = (cell_rq[lv-1].vld && !cell_rq[lv-1].up)
                                      ? cell_rq[lv-1].row : '0;
                assign pk_above[lv] = (cell_out[lv-1].vld && !cell_out[lv-1].up)
                                      ? cell_out[lv-1] : '0;
                assign nb_up[lv]    = ram_rd[lv-1];
            end
            else
            begin : g_root
                assign rq_above[lv] = '0;
                assign pk_above[lv] = '0;
                assign nb_up[lv]    = '0;
            end

            if (lv < LVLS - 1)
            begin : g_below
                assign rq_below[lv] = (cell_rq[lv+1].vld && cell_rq[lv+1].up)
                                      ? cell_rq[lv+1].row : '0;
                assign pk_below[lv] = (cell_out[lv+1].vld && cell_out[lv+1].up)
                                      ? cell_out[lv+1] : '0;
                assign nb_dn[lv]    = ram_rd[lv+1];
            end
            else
            begin : g_leaf
                assign rq_below[lv] = '0;
                assign pk_below[lv] = '0;
                assign nb_dn[lv]    = '0;
            end

            assign fetch_row = (state_reg == S_FETCH && last_lvl_reg == LVL_W'(lv))
                               ? (last_off_reg >> 1) : '0;
            assign row_full  = rq_above[lv] | rq_below[lv] | fetch_row;
            assign inj_here  = (inj_reg.vld && inj_lvl_reg == LVL_W'(lv)) ? inj_reg : '0;
            assign cell_in[lv] = inj_here | pk_above[lv] | pk_below[lv];
            assign we = {cell_wr[lv].vld && cell_wr[lv].side,
                         cell_wr[lv].vld && !cell_wr[lv].side};

            hbpq_ram #(
                .ROWS (ROWS),
                .AW   (AW)
            ) u_ram (
                .clk     (clk),
                .we      (we),
                .wr_row  (cell_wr[lv].row[AW-1:0]),
                .wr_data (cell_wr[lv].data),
                .rd_row  (row_full[AW-1:0]),
                .rd_data (ram_rd[lv])
            );

            hbpq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .pkt_in  (cell_in[lv]),
                .pkt_out (cell_out[lv]),
                .rd_up   (nb_up[lv]),
                .rd_dn   (nb_dn[lv]),
                .rq      (cell_rq[lv]),
                .wr      (cell_wr[lv]),
                .done    (cell_done[lv])
            );
        end
    endgenerate

    // request sequencing
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign ins_pos   = IDX_W'(count_reg);
    assign last_pos  = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        inj_next      = inj_reg;
        inj_next.vld  = 1'b0;
        inj_lvl_next  = inj_lvl_reg;
        last_lvl_next = last_lvl_reg;
        last_off_next = last_off_reg;
        res_val_next  = res_val_reg;
        res_st_next   = res_st_reg;
        out_vld_next  = out_vld_reg && !rsp.ready;
        out_val_next  = out_val_reg;
        out_st_next   = out_st_reg;
        out_cnt_next  = out_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_val_next = MOST_NEG;
                    if (req.cmd == CMD_INSERT)
                    begin
                        if (count_reg >= cap_eff)
                        begin
                            res_st_next = ST_DROPPED;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            inj_next.vld = 1'b1;
                            inj_next.up  = 1'b1;
                            inj_next.val = req.value_in;
                            inj_next.idx = ins_pos;
                            inj_next.off = idx_off(ins_pos);
                            inj_lvl_next = idx_lvl(ins_pos);
                            count_next   = count_reg + CNT_W'(1);
                            res_st_next  = ST_INSERTED;
                            state_next   = S_WAIT;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_st_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            last_lvl_next = idx_lvl(last_pos);
                            last_off_next = idx_off(last_pos);
                            count_next    = count_reg - CNT_W'(1);
                            res_st_next   = ST_REMOVED;
                            state_next    = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                res_val_next = ram_rd[0][0];
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    inj_next.vld = 1'b1;
                    inj_next.up  = 1'b0;
                    inj_next.val = ram_rd[last_lvl_reg][last_off_reg[0]];
                    inj_next.idx = '0;
                    inj_next.off = '0;
                    inj_lvl_next = '0;
                    state_next   = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (|cell_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next = 1'b1;
                    out_val_next = res_val_reg;
                    out_st_next  = res_st_reg;
                    out_cnt_next = count_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            inj_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            inj_reg     <= inj_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inj_lvl_reg  <= inj_lvl_next;
        last_lvl_reg <= last_lvl_next;
        last_off_reg <= last_off_next;
        res_val_reg  <= res_val_next;
        res_st_reg   <= res_st_next;
        out_val_reg  <= out_val_next;
        out_st_reg   <= out_st_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.value_out   = out_val_reg;
    assign rsp.status      = out_st_reg;
    assign rsp.entry_count = out_cnt_reg;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for binary_heap_priority_queue_unit: directed and random insert/remove
// requests checked against an in-bench heap image, with APB register writes between phases.
// Depends on hbpq_pkg, hbpq_ifs and the RTL of the heap queue.
module tb_top import hbpq_pkg::*; ();

    localparam int CYCLE_LIMIT    = 600000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 24;
    localparam logic signed [VAL_W-1:0] MOST_POS = ~MOST_NEG;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [1:0]              status;
        logic [CNT_W-1:0]        count;
    } heap_result_t;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    hbpq_req_if req_ch ();
    hbpq_rsp_if rsp_ch ();

    logic signed [VAL_W-1:0] heap_img [DEPTH];
    int                      entries_img;
    logic                    min_order_img;
    logic [CNT_W-1:0]        cap_img;
    heap_result_t            awaited_results [$];
    int                      status_tally [4];
    int                      error_count;
    int                      cycle_count;
    bit                      bursts_on;
    bit                      holdoff_req;

    binary_heap_priority_queue_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    function automatic logic ranks_higher(input logic signed [VAL_W-1:0] a,
                                          input logic signed [VAL_W-1:0] b);
        return min_order_img ? (a < b) : (a > b);
    endfunction

    function automatic heap_result_t heap_apply_request(input logic c,
                                                        input logic signed [VAL_W-1:0] v);
        heap_result_t            r;
        int                      lim;
        int                      pos;
        int                      nxt;
        int                      lc;
        logic signed [VAL_W-1:0] tmp;
        r.value = MOST_NEG;
        if (c == CMD_INSERT)
        begin
            lim = (cap_img > DEPTH) ? DEPTH : int'(cap_img);
            if (entries_img >= lim)
            begin
                r.status = ST_DROPPED;
            end
            else
            begin
                heap_img[entries_img] = v;
                pos = entries_img;
                while (pos > 0)
                begin
                    nxt = (pos - 1) / 2;
                    if (!ranks_higher(heap_img[pos], heap_img[nxt]))
                    begin
                        break;
                    end
                    tmp           = heap_img[pos];
                    heap_img[pos] = heap_img[nxt];
                    heap_img[nxt] = tmp;
                    pos           = nxt;
                end
                entries_img++;
                r.status = ST_INSERTED;
            end
        end
        else if (entries_img == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            r.value     = heap_img[0];
            heap_img[0] = heap_img[entries_img-1];
            entries_img--;
            pos = 0;
            while (2 * pos + 1 < entries_img)
            begin
                lc  = 2 * pos + 1;
                nxt = (lc + 1 >= entries_img || ranks_higher(heap_img[lc], heap_img[lc+1]))
                      ? lc : lc + 1;
                if (!ranks_higher(heap_img[nxt], heap_img[pos]))
                begin
                    break;
                end
                tmp           = heap_img[pos];
                heap_img[pos] = heap_img[nxt];
                heap_img[nxt] = tmp;
                pos           = nxt;
            end
            r.status = ST_REMOVED;
        end
        r.count = CNT_W'(entries_img);
        status_tally[r.status]++;
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return VAL_W'(int'($urandom_range(0, 7)) - 4);
            1:       return MOST_NEG + $urandom_range(0, 3);
            2:       return MOST_POS - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic c, input logic signed [VAL_W-1:0] v);
        if (bursts_on && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.cmd      = c;
        req_ch.value_in = v;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        awaited_results.push_back(heap_apply_request(c, v));
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        req_ch.valid = 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] data);
        wait_until_drained();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx) << 2;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (idx == REG_MODE)
        begin
            min_order_img = data[0];
        end
        else
        begin
            cap_img = data[CNT_W-1:0];
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic test_empty_remove();
        send_request(CMD_REMOVE, MOST_POS);
    endtask

    task automatic test_min_order_extremes();
        send_request(CMD_INSERT, MOST_POS);
        send_request(CMD_INSERT, MOST_NEG);
        send_request(CMD_INSERT, 0);
        send_request(CMD_INSERT, -1);
        send_request(CMD_INSERT, 3);
        send_request(CMD_INSERT, 3);
        repeat (2) send_request(CMD_REMOVE, 0);
    endtask

    task automatic test_order_switch();
        write_register(REG_MODE, 32'd0);
        send_request(CMD_INSERT, MOST_NEG + 1);
        send_request(CMD_INSERT, MOST_POS - 1);
        repeat (7) send_request(CMD_REMOVE, $urandom);
    endtask

    task automatic test_capacity_edges();
        write_register(REG_CAP, 32'd1);
        send_request(CMD_INSERT, 7);
        send_request(CMD_INSERT, 8);
        send_request(CMD_REMOVE, 0);
        write_register(REG_CAP, 32'd0);
        send_request(CMD_INSERT, 9);
        write_register(REG_CAP, 32'(DEPTH));
        repeat (3) send_request(CMD_INSERT, pick_value());
        write_register(REG_CAP, 32'd2);
        send_request(CMD_INSERT, 10);
        repeat (3) send_request(CMD_REMOVE, 0);
    endtask

    task automatic test_fill_to_depth();
        write_register(REG_MODE, 32'd0);
        write_register(REG_CAP, 32'd511);
        repeat (DEPTH + 1) send_request(CMD_INSERT, pick_value());
        repeat (DEPTH + 1) send_request(CMD_REMOVE, $urandom);
    endtask

    task automatic test_output_holdoff();
        write_register(REG_MODE, 32'd1);
        write_register(REG_CAP, 32'(DEPTH));
        holdoff_req = 1'b1;
        repeat (24)
        begin
            send_request(($urandom_range(0, 99) < 70) ? CMD_INSERT : CMD_REMOVE, pick_value());
        end
        wait_until_drained();
    endtask

    task automatic run_random_phase(input logic order, input int cap, input int n,
                                    input int insert_pct);
        write_register(REG_MODE, 32'(order));
        write_register(REG_CAP, 32'(cap));
        repeat (n)
        begin
            send_request(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                         pick_value());
        end
    endtask

    task automatic test_random_mix();
        run_random_phase(1'b1, DEPTH, 330, 60);
        run_random_phase(1'b0, 16, 250, 55);
        run_random_phase(1'b1, 1, 120, 50);
        run_random_phase(1'b0, 200, 250, 65);
        run_random_phase(1'b1, 0, 30, 50);
        bursts_on = 1'b0;
        run_random_phase(1'b0, 511, 200, 50);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (holdoff_req)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
                holdoff_req = 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 15) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge clk);
            end
            else
            begin
                rsp_ch.ready = 1'b1;
            end
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        heap_result_t exp_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result value %0d status %0d count %0d", $time,
                         rsp_ch.value_out, rsp_ch.status, rsp_ch.entry_count);
            end
            else
            begin
                exp_r = awaited_results.pop_front();
                if (rsp_ch.value_out !== exp_r.value)
                begin
                    error_count++;
                    $display("%0t: value_out expected %0d actual %0d", $time,
                             exp_r.value, rsp_ch.value_out);
                end
                if (rsp_ch.status !== exp_r.status)
                begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, rsp_ch.status);
                end
                if (rsp_ch.entry_count !== exp_r.count)
                begin
                    error_count++;
                    $display("%0t: entry_count expected %0d actual %0d", $time,
                             exp_r.count, rsp_ch.entry_count);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_INSERT;
        req_ch.value_in = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        bursts_on       = 1'b1;
        holdoff_req     = 1'b0;
        entries_img     = 0;
        min_order_img   = 1'b1;
        cap_img         = DEPTH_CNT;
        error_count     = 0;
        status_tally    = '{0, 0, 0, 0};
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_remove();
        test_min_order_extremes();
        test_order_switch();
        test_capacity_edges();
        test_fill_to_depth();
        test_output_holdoff();
        test_random_mix();
        wait_until_drained();
        $display("tb_top: %0d requests: %0d inserted, %0d dropped full, %0d removed, %0d empty",
                 status_tally[ST_INSERTED] + status_tally[ST_DROPPED]
                 + status_tally[ST_REMOVED] + status_tally[ST_EMPTY],
                 status_tally[ST_INSERTED], status_tally[ST_DROPPED],
                 status_tally[ST_REMOVED], status_tally[ST_EMPTY]);
        $display("tb_top: min and max order, capacities 0 to 511, full heap, %0d-cycle hold-off",
                 HOLDOFF_CYCLES);
        if (error_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
